/* design/cll_pkg.sv */
// ----------------------------------------------------------------------------
// cll_pkg
// Shared types, codes and helpers of the combination lock controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cll_pkg;

  // Default width of the tick clock and its stamps
  localparam int unsigned TIME_WIDTH_DEF = 32;

  // Configuration port
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_TRIES        = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOCKOUT_SECONDS  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_BUTTON_HOLDOFF   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SELECT_HOLDOFF   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_SECOND = 3'd4;

  // Register reset values
  localparam logic [3:0]  MAX_TRIES_RST        = 4'd3;
  localparam logic [6:0]  LOCKOUT_SECONDS_RST  = 7'd5;
  localparam logic [15:0] BUTTON_HOLDOFF_RST   = 16'd250;
  localparam logic [15:0] SELECT_HOLDOFF_RST   = 16'd300;
  localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd1000;

  // Lock modes (state codes)
  localparam logic [1:0] MODE_OPEN    = 2'd0;
  localparam logic [1:0] MODE_CLOSED  = 2'd1;
  localparam logic [1:0] MODE_SETTING = 2'd2;
  localparam logic [1:0] MODE_BLOCKED = 2'd3;

  localparam logic [1:0] SEL_FIRST = 2'd0;
  localparam logic [1:0] SEL_LAST  = 2'd2;
  localparam logic [3:0] DIGIT_MAX = 4'd9;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_WRONG   = 3'd1,
    EV_LOCKOUT = 3'd2,
    EV_OPENED  = 3'd3,
    EV_SAVED   = 3'd4,
    EV_OVER    = 3'd5
  } cll_event_e;

  typedef struct packed {
    logic [3:0]  max_tries;
    logic [6:0]  lockout_seconds;
    logic [15:0] button_holdoff;
    logic [15:0] select_holdoff;
    logic [15:0] ticks_per_second;
  } cll_cfg_t;

  typedef struct packed {
    logic encoder_a;
    logic encoder_b;
    logic select_button_n;
    logic confirm_button;
    logic clear_button;
    logic door_sensor;
  } cll_pins_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] sel;
    logic [3:0] d1;
    logic [3:0] d2;
    logic [3:0] d3;
    logic [9:0] code;
    logic [3:0] tries;
    logic [6:0] count;
    logic       last_a;
    logic       green;
    logic       bolt;
  } cll_state_t;

  // Cycle select 0, 1, 2, 0
  function automatic logic [1:0] next_sel(input logic [1:0] sel);
    next_sel = (sel >= SEL_LAST) ? SEL_FIRST : sel + 2'd1;
  endfunction

  // Step one digit up or down with wrap in 0-9
  function automatic logic [3:0] digit_step(input logic [3:0] d, input logic up);
    if (up) begin
      digit_step = (d >= DIGIT_MAX) ? 4'd0 : d + 4'd1;
    end else begin
      digit_step = (d == 4'd0 || d > DIGIT_MAX) ? DIGIT_MAX : d - 4'd1;
    end
  endfunction

  // 100*d1 + 10*d2 + d3, wide enough for any 4-bit digits
  function automatic logic [10:0] code_of(input logic [3:0] d1, input logic [3:0] d2,
                                          input logic [3:0] d3);
    code_of = 11'(d1) * 11'd100 + 11'(d2) * 11'd10 + 11'(d3);
  endfunction

  // Tens (mod 10) and units of a 7-bit count; reciprocal multiply for /10
  function automatic logic [7:0] count_digits(input logic [6:0] n);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(n) * 15'd205;
    tens  = prod[14:11];
    units = n - 7'(tens) * 7'd10;
    if (tens >= 4'd10) begin
      tens = tens - 4'd10;
    end
    count_digits = {tens, units[3:0]};
  endfunction

endpackage

`default_nettype wire

/* design/cll_req_if.sv */
// ----------------------------------------------------------------------------
// cll_req_if
// Request channel: one tick of lock pin samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface cll_req_if;
  logic valid;
  logic ready;
  logic encoder_a;
  logic encoder_b;
  logic select_button_n;
  logic confirm_button;
  logic clear_button;
  logic door_sensor;

  modport source (
    output valid, encoder_a, encoder_b, select_button_n, confirm_button,
           clear_button, door_sensor,
    input  ready
  );

  modport sink (
    input  valid, encoder_a, encoder_b, select_button_n, confirm_button,
           clear_button, door_sensor,
    output ready
  );
endinterface

`default_nettype wire

/* design/cll_res_if.sv */
// ----------------------------------------------------------------------------
// cll_res_if
// Result channel: lock state after one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface cll_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [1:0] selected_digit;
  logic [3:0] digit_one;
  logic [3:0] digit_two;
  logic [3:0] digit_three;
  logic       bolt_open;
  logic       green_led;
  logic       red_led;
  logic [2:0] event_res;
  logic [3:0] tries_left;

  modport source (
    output valid, mode, selected_digit, digit_one, digit_two, digit_three,
           bolt_open, green_led, red_led, event_res, tries_left,
    input  ready
  );

  modport sink (
    input  valid, mode, selected_digit, digit_one, digit_two, digit_three,
           bolt_open, green_led, red_led, event_res, tries_left,
    output ready
  );
endinterface

`default_nettype wire

/* design/cll_cfg_if.sv */
// ----------------------------------------------------------------------------
// cll_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface cll_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

/* design/cll_step.sv */
// ----------------------------------------------------------------------------
// cll_step
// Next-state logic of the lock for one tick of pin samples.
// ----------------------------------------------------------------------------
`default_nettype none

module cll_step
  import cll_pkg::*;
#(
  parameter int unsigned TimeWidth = TIME_WIDTH_DEF
) (
  input  cll_cfg_t             cfg_i,
  input  cll_pins_t            pins_i,
  input  cll_state_t           st_i,
  input  logic [TimeWidth-1:0] tick_i,
  input  logic [TimeWidth-1:0] confirm_stamp_i,
  input  logic [TimeWidth-1:0] clear_stamp_i,
  input  logic [TimeWidth-1:0] select_stamp_i,
  input  logic [TimeWidth-1:0] countdown_stamp_i,
  output cll_state_t           st_o,
  output logic [TimeWidth-1:0] tick_o,
  output logic [TimeWidth-1:0] confirm_stamp_o,
  output logic [TimeWidth-1:0] clear_stamp_o,
  output logic [TimeWidth-1:0] select_stamp_o,
  output logic [TimeWidth-1:0] countdown_stamp_o,
  output cll_event_e           event_o
);

  logic [TimeWidth-1:0] tick_n;
  logic                 confirm_ok, clear_ok, select_ok, second_due;
  logic [1:0]           handled;
  logic [10:0]          entered_code;
  logic [7:0]           count_split;
  cll_state_t           enc_st;

  assign tick_n = tick_i + TimeWidth'(1);

  // Holdoff checks against the advanced clock
  assign confirm_ok = pins_i.confirm_button &&
                      ((tick_n - confirm_stamp_i) > TimeWidth'(cfg_i.button_holdoff));
  assign clear_ok   = pins_i.clear_button &&
                      ((tick_n - clear_stamp_i) > TimeWidth'(cfg_i.button_holdoff));
  assign select_ok  = !pins_i.select_button_n &&
                      ((tick_n - select_stamp_i) > TimeWidth'(cfg_i.select_holdoff));
  assign second_due = (tick_n - countdown_stamp_i) > TimeWidth'(cfg_i.ticks_per_second);

  assign handled      = pins_i.door_sensor ? MODE_CLOSED : st_i.mode;
  assign entered_code = code_of(st_i.d1, st_i.d2, st_i.d3);
  assign count_split  = count_digits(st_i.count);

  // Encoder step on the digit selected at the start of the tick
  always_comb begin
    enc_st        = st_i;
    enc_st.last_a = pins_i.encoder_a;
    if (!st_i.last_a && pins_i.encoder_a) begin
      unique case (st_i.sel)
        2'd0:    enc_st.d1 = digit_step(st_i.d1, pins_i.encoder_b);
        2'd1:    enc_st.d2 = digit_step(st_i.d2, pins_i.encoder_b);
        2'd2:    enc_st.d3 = digit_step(st_i.d3, pins_i.encoder_b);
        default: enc_st.d1 = st_i.d1;
      endcase
    end
  end

  always_comb begin
    st_o              = st_i;
    tick_o            = tick_n;
    confirm_stamp_o   = confirm_stamp_i;
    clear_stamp_o     = clear_stamp_i;
    select_stamp_o    = select_stamp_i;
    countdown_stamp_o = countdown_stamp_i;
    event_o           = EV_NONE;

    unique case (handled)
      MODE_OPEN: begin
        st_o.green = 1'b1;
        if (clear_ok) begin
          clear_stamp_o = tick_n;
          st_o.mode     = MODE_SETTING;
        end else if (confirm_ok) begin
          confirm_stamp_o = tick_n;
          st_o.mode       = MODE_CLOSED;
          st_o.bolt       = 1'b0;
          st_o.green      = 1'b0;
        end
      end
      MODE_CLOSED: begin
        if (clear_ok) begin
          clear_stamp_o = tick_n;
          st_o.d1       = 4'd0;
          st_o.d2       = 4'd0;
          st_o.d3       = 4'd0;
        end else if (confirm_ok) begin
          confirm_stamp_o = tick_n;
          if (entered_code == {1'b0, st_i.code}) begin
            st_o.green = 1'b1;
            st_o.bolt  = 1'b1;
            st_o.mode  = MODE_OPEN;
            event_o    = EV_OPENED;
          end else if (st_i.tries <= 4'd1) begin
            st_o.tries = 4'd0;
            st_o.mode  = MODE_BLOCKED;
            st_o.count = cfg_i.lockout_seconds;
            event_o    = EV_LOCKOUT;
          end else begin
            st_o.tries = st_i.tries - 4'd1;
            event_o    = EV_WRONG;
          end
        end else begin
          st_o.d1     = enc_st.d1;
          st_o.d2     = enc_st.d2;
          st_o.d3     = enc_st.d3;
          st_o.last_a = enc_st.last_a;
        end
        if (select_ok) begin
          select_stamp_o = tick_n;
          st_o.sel       = next_sel(st_i.sel);
        end
      end
      MODE_SETTING: begin
        if (confirm_ok) begin
          confirm_stamp_o = tick_n;
          st_o.code       = entered_code[9:0];
          st_o.bolt       = 1'b0;
          st_o.green      = 1'b0;
          st_o.mode       = MODE_CLOSED;
          event_o         = EV_SAVED;
        end else if (select_ok) begin
          select_stamp_o = tick_n;
          st_o.sel       = next_sel(st_i.sel);
        end else begin
          st_o.d1     = enc_st.d1;
          st_o.d2     = enc_st.d2;
          st_o.d3     = enc_st.d3;
          st_o.last_a = enc_st.last_a;
        end
      end
      default: begin
        // Blocked: show and step the countdown once a second
        if (second_due) begin
          st_o.d1 = 4'd0;
          st_o.d2 = count_split[7:4];
          st_o.d3 = count_split[3:0];
          if (st_i.count == 7'd0) begin
            st_o.tries = cfg_i.max_tries;
            st_o.mode  = MODE_CLOSED;
            event_o    = EV_OVER;
          end else begin
            st_o.count        = st_i.count - 7'd1;
            countdown_stamp_o = tick_n;
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/combination_lock_controller.sv */
// ----------------------------------------------------------------------------
// combination_lock_controller
// Three-digit combination lock with try counter and timed lockout.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per millisecond tick: encoder A/B samples, the
//   select (active low), confirm and clear buttons and the door sensor.
//   res_o returns exactly one result per request: mode, selected digit, the
//   three shown digits, bolt, lamps, event code and tries left, all as they
//   stand after that tick.
//   cfg_i writes the five registers (max tries, lockout seconds, button and
//   select holdoffs, ticks per second) by index; it is always ready and an
//   unknown index is dropped. Write only while no request is in flight.
// Timing:
//   A request is worked out by the next-state logic and lands in the state
//   registers, which double as the result register: one request per cycle
//   while the receiver keeps taking results. The single state register set
//   fixes that rate.
// Reset and stalls:
//   Reset closes the lock, clears digits, code and time stamps and loads the
//   register defaults. While the receiver holds off, the result is held and
//   req_i.ready stays low until the result is taken; a request is taken in
//   the same cycle as the pending result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module combination_lock_controller
  import cll_pkg::*;
#(
  parameter int unsigned TimeWidth = TIME_WIDTH_DEF
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  cll_req_if.sink   req_i,
  cll_res_if.source res_o,
  cll_cfg_if.sink   cfg_i
);

  cll_cfg_t             cfg_q;
  cll_state_t           st_q, st_d;
  cll_pins_t            pins;
  cll_event_e           event_q, event_d;
  logic                 res_valid_q;
  logic                 req_fire, res_fire, cfg_fire;
  logic [TimeWidth-1:0] tick_q, tick_d;
  logic [TimeWidth-1:0] confirm_stamp_q, confirm_stamp_d;
  logic [TimeWidth-1:0] clear_stamp_q, clear_stamp_d;
  logic [TimeWidth-1:0] select_stamp_q, select_stamp_d;
  logic [TimeWidth-1:0] countdown_stamp_q, countdown_stamp_d;

  // Handshakes: take a request whenever the result slot is free or draining
  assign req_i.ready = !res_valid_q || res_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;
  assign res_fire    = res_o.valid && res_o.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  assign pins = '{
    encoder_a:       req_i.encoder_a,
    encoder_b:       req_i.encoder_b,
    select_button_n: req_i.select_button_n,
    confirm_button:  req_i.confirm_button,
    clear_button:    req_i.clear_button,
    door_sensor:     req_i.door_sensor
  };

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_tries        <= MAX_TRIES_RST;
      cfg_q.lockout_seconds  <= LOCKOUT_SECONDS_RST;
      cfg_q.button_holdoff   <= BUTTON_HOLDOFF_RST;
      cfg_q.select_holdoff   <= SELECT_HOLDOFF_RST;
      cfg_q.ticks_per_second <= TICKS_PER_SECOND_RST;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        CFG_MAX_TRIES:        cfg_q.max_tries        <= cfg_i.data[3:0];
        CFG_LOCKOUT_SECONDS:  cfg_q.lockout_seconds  <= cfg_i.data[6:0];
        CFG_BUTTON_HOLDOFF:   cfg_q.button_holdoff   <= cfg_i.data;
        CFG_SELECT_HOLDOFF:   cfg_q.select_holdoff   <= cfg_i.data;
        CFG_TICKS_PER_SECOND: cfg_q.ticks_per_second <= cfg_i.data;
        default:              cfg_q                  <= cfg_q;
      endcase
    end
  end

  // One tick of lock behaviour
  cll_step #(
    .TimeWidth (TimeWidth)
  ) u_step (
    .cfg_i             (cfg_q),
    .pins_i            (pins),
    .st_i              (st_q),
    .tick_i            (tick_q),
    .confirm_stamp_i   (confirm_stamp_q),
    .clear_stamp_i     (clear_stamp_q),
    .select_stamp_i    (select_stamp_q),
    .countdown_stamp_i (countdown_stamp_q),
    .st_o              (st_d),
    .tick_o            (tick_d),
    .confirm_stamp_o   (confirm_stamp_d),
    .clear_stamp_o     (clear_stamp_d),
    .select_stamp_o    (select_stamp_d),
    .countdown_stamp_o (countdown_stamp_d),
    .event_o           (event_d)
  );

  // State advances only on an accepted request; it also holds the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.mode         <= MODE_CLOSED;
      st_q.sel          <= SEL_FIRST;
      st_q.d1           <= 4'd0;
      st_q.d2           <= 4'd0;
      st_q.d3           <= 4'd0;
      st_q.code         <= 10'd0;
      st_q.tries        <= MAX_TRIES_RST;
      st_q.count        <= LOCKOUT_SECONDS_RST;
      st_q.last_a       <= 1'b0;
      st_q.green        <= 1'b0;
      st_q.bolt         <= 1'b0;
      event_q           <= EV_NONE;
      tick_q            <= '0;
      confirm_stamp_q   <= '0;
      clear_stamp_q     <= '0;
      select_stamp_q    <= '0;
      countdown_stamp_q <= '0;
    end else if (req_fire) begin
      st_q              <= st_d;
      event_q           <= event_d;
      tick_q            <= tick_d;
      confirm_stamp_q   <= confirm_stamp_d;
      clear_stamp_q     <= clear_stamp_d;
      select_stamp_q    <= select_stamp_d;
      countdown_stamp_q <= countdown_stamp_d;
    end
  end

  // Result valid: set on a request, drop once taken without a new one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (req_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_fire) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.mode           = st_q.mode;
  assign res_o.selected_digit = st_q.sel;
  assign res_o.digit_one      = st_q.d1;
  assign res_o.digit_two      = st_q.d2;
  assign res_o.digit_three    = st_q.d3;
  assign res_o.bolt_open      = st_q.bolt;
  assign res_o.green_led      = st_q.green;
  assign res_o.red_led        = (st_q.mode == MODE_BLOCKED);
  assign res_o.event_res      = event_q;
  assign res_o.tries_left     = st_q.tries;

  // Shown digits never leave 0-9
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.d1 <= DIGIT_MAX && st_q.d2 <= DIGIT_MAX && st_q.d3 <= DIGIT_MAX)
    else $error("shown digit out of range");

  // Tick clock moves by one per accepted request and holds otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> tick_q == $past(tick_q) + TimeWidth'(1))
    else $error("tick clock did not advance on request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_fire |=> $stable(tick_q) && $stable(st_q))
    else $error("state changed without a request");

  // Events agree with the state they report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && event_q == EV_OPENED |-> st_q.mode == MODE_OPEN && st_q.bolt)
    else $error("open event without open bolt");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && event_q == EV_LOCKOUT |-> st_q.mode == MODE_BLOCKED && st_q.tries == 4'd0)
    else $error("lockout event without blocked mode");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire && event_d == EV_SAVED |=> st_q.code == $past(st_d.code) && !st_q.bolt)
    else $error("saved code not held");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the combination lock controller. A behavioural
// lock model inside a scoreboard class predicts every result from the pin
// samples of each accepted request. Directed ticks exercise the encoder,
// select, confirm, clear, door and lockout paths, then sequenced random
// traffic (code entry, code changes, wrong-code runs, pin noise) runs across
// several register settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cll_pkg::*;

  localparam int TOTAL_TICKS   = 1550;    // no new settings phase starts after this
  localparam int CYCLE_LIMIT   = 400000;  // watchdog, several times the slowest run
  localparam int RESET_CYCLES  = 7;
  localparam int GAP_MAX       = 14;      // longest idle draw on either side
  localparam int LONG_HOLD     = 300;     // receiver hold-off to back the block up
  localparam int DRAIN_LIMIT   = 2000;    // cycles allowed for results to drain
  localparam int SETTLE_CYCLES = 4;       // slack after the results drain
  localparam int WAIT_CAP      = 24;      // longest wait for a button hold-off
  localparam int LOCKOUT_CAP   = 250;     // most ticks spent waiting out a lockout
  localparam int LOG_CAP       = 100;     // mismatch lines printed at most

  // Index with no register behind it: the block must drop the write
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 3'd7;

  typedef enum int {BTN_SELECT, BTN_CONFIRM, BTN_CLEAR} button_e;

  // One result as seen on the result channel
  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] sel;
    logic [3:0] d1;
    logic [3:0] d2;
    logic [3:0] d3;
    logic       bolt;
    logic       green;
    logic       red;
    logic [2:0] ev;
    logic [3:0] tries;
  } lock_view_t;

  // --------------------------------------------------------------------------
  // Lock model and result store
  // --------------------------------------------------------------------------
  class lock_scoreboard;
    // registers
    bit [3:0]  max_tries;
    bit [6:0]  lockout_secs;
    bit [15:0] button_hold;
    bit [15:0] select_hold;
    bit [15:0] tick_rate;
    // lock state
    bit [1:0]  mode;
    bit [1:0]  dsel;
    bit [3:0]  digit [3];
    bit [9:0]  stored;
    bit [3:0]  tries;
    bit [6:0]  count;
    bit [31:0] now, confirm_t, clear_t, select_t, count_t;
    bit        prev_a, green, bolt;
    // results still owed by the block
    lock_view_t due_q[$];
    int errors;
    int checked;
    int ev_seen [8];

    function new();
      max_tries    = MAX_TRIES_RST;
      lockout_secs = LOCKOUT_SECONDS_RST;
      button_hold  = BUTTON_HOLDOFF_RST;
      select_hold  = SELECT_HOLDOFF_RST;
      tick_rate    = TICKS_PER_SECOND_RST;
      mode         = MODE_CLOSED;
      dsel         = SEL_FIRST;
      digit        = '{default: 4'd0};
      stored       = '0;
      tries        = max_tries;
      count        = lockout_secs;
      now          = '0;
      confirm_t    = '0;
      clear_t      = '0;
      select_t     = '0;
      count_t      = '0;
      prev_a       = 1'b0;
      green        = 1'b0;
      bolt         = 1'b0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAX_TRIES:        max_tries    = data[3:0];
        CFG_LOCKOUT_SECONDS:  lockout_secs = data[6:0];
        CFG_BUTTON_HOLDOFF:   button_hold  = data;
        CFG_SELECT_HOLDOFF:   select_hold  = data;
        CFG_TICKS_PER_SECOND: tick_rate    = data;
        default: ;
      endcase
    endfunction

    function bit [31:0] stamp_of(button_e k);
      case (k)
        BTN_SELECT:  return select_t;
        BTN_CONFIRM: return confirm_t;
        default:     return clear_t;
      endcase
    endfunction

    function bit [15:0] hold_of(button_e k);
      return (k == BTN_SELECT) ? select_hold : button_hold;
    endfunction

    // Would a press on the next tick clear its hold-off?
    function bit will_take(button_e k);
      bit [31:0] gap;
      gap = now + 32'd1 - stamp_of(k);
      return gap > {16'd0, hold_of(k)};
    endfunction

    // Accept a press once the hold-off has run out and restamp it
    function bit take(button_e k, bit pressed);
      bit [31:0] gap;
      gap = now - stamp_of(k);
      if (!pressed || gap <= {16'd0, hold_of(k)}) return 1'b0;
      case (k)
        BTN_SELECT:  select_t  = now;
        BTN_CONFIRM: confirm_t = now;
        default:     clear_t   = now;
      endcase
      return 1'b1;
    endfunction

    function void advance_sel();
      dsel = (dsel >= SEL_LAST) ? SEL_FIRST : dsel + 2'd1;
    endfunction

    function int entered_code();
      return int'(digit[0]) * 100 + int'(digit[1]) * 10 + int'(digit[2]);
    endfunction

    // Step the digit on a rising edge of A; B low turns it down
    function void step_digit(bit [1:0] s, bit a, bit b);
      bit [3:0] d;
      if (!prev_a && a && s <= SEL_LAST) begin
        d = digit[s];
        if (!b) begin
          d = (d == 4'd0 || d > DIGIT_MAX) ? DIGIT_MAX : d - 4'd1;
        end else begin
          d = (d >= DIGIT_MAX) ? 4'd0 : d + 4'd1;
        end
        digit[s] = d;
      end
      prev_a = a;
    endfunction

    // Advance the model by one accepted tick and queue the result it owes
    function void note_request(cll_pins_t p);
      bit [1:0]   handled;
      bit [1:0]   sel0;
      cll_event_e ev;
      lock_view_t v;
      ev      = EV_NONE;
      now     = now + 32'd1;
      handled = p.door_sensor ? MODE_CLOSED : mode;
      sel0    = dsel;
      case (handled)
        MODE_OPEN: begin
          green = 1'b1;
          if (take(BTN_CLEAR, p.clear_button)) begin
            mode = MODE_SETTING;
          end else if (take(BTN_CONFIRM, p.confirm_button)) begin
            mode  = MODE_CLOSED;
            bolt  = 1'b0;
            green = 1'b0;
          end
        end
        MODE_CLOSED: begin
          if (take(BTN_SELECT, !p.select_button_n)) advance_sel();
          if (take(BTN_CLEAR, p.clear_button)) begin
            digit = '{default: 4'd0};
          end else if (take(BTN_CONFIRM, p.confirm_button)) begin
            if (entered_code() == int'(stored)) begin
              green = 1'b1;
              bolt  = 1'b1;
              mode  = MODE_OPEN;
              ev    = EV_OPENED;
            end else if (tries <= 4'd1) begin
              tries = 4'd0;
              mode  = MODE_BLOCKED;
              count = lockout_secs;
              ev    = EV_LOCKOUT;
            end else begin
              tries = tries - 4'd1;
              ev    = EV_WRONG;
            end
          end else begin
            step_digit(sel0, p.encoder_a, p.encoder_b);
          end
        end
        MODE_SETTING: begin
          if (take(BTN_CONFIRM, p.confirm_button)) begin
            stored = 10'(entered_code());
            bolt   = 1'b0;
            green  = 1'b0;
            mode   = MODE_CLOSED;
            ev     = EV_SAVED;
          end else if (take(BTN_SELECT, !p.select_button_n)) begin
            advance_sel();
          end else begin
            step_digit(sel0, p.encoder_a, p.encoder_b);
          end
        end
        default: begin
          if (now - count_t > {16'd0, tick_rate}) begin
            digit[0] = 4'd0;
            digit[1] = 4'(count / 7'd10 % 7'd10);
            digit[2] = 4'(count % 7'd10);
            if (count == 7'd0) begin
              tries = max_tries;
              mode  = MODE_CLOSED;
              ev    = EV_OVER;
            end else begin
              count   = count - 7'd1;
              count_t = now;
            end
          end
        end
      endcase
      v.mode  = mode;
      v.sel   = dsel;
      v.d1    = digit[0];
      v.d2    = digit[1];
      v.d3    = digit[2];
      v.bolt  = bolt;
      v.green = green;
      v.red   = (mode == MODE_BLOCKED);
      v.ev    = ev;
      v.tries = tries;
      due_q.push_back(v);
      ev_seen[ev]++;
    endfunction

    function void cmp(string name, logic [3:0] want, logic [3:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= LOG_CAP) begin
          $display("%0t: result %0d %s expected %0d got %0d", $time, checked, name, want, got);
        end
      end
    endfunction

    function void check_result(lock_view_t got);
      lock_view_t want;
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding", $time);
        return;
      end
      want = due_q.pop_front();
      checked++;
      cmp("mode",           want.mode,  got.mode);
      cmp("selected_digit", want.sel,   got.sel);
      cmp("digit_one",      want.d1,    got.d1);
      cmp("digit_two",      want.d2,    got.d2);
      cmp("digit_three",    want.d3,    got.d3);
      cmp("bolt_open",      want.bolt,  got.bolt);
      cmp("green_led",      want.green, got.green);
      cmp("red_led",        want.red,   got.red);
      cmp("event_res",      want.ev,    got.ev);
      cmp("tries_left",     want.tries, got.tries);
    endfunction

    function int pending();
      return due_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, block under test
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;
  int   cycles = 0;
  int   ticks_sent = 0;
  int   tx_gap_max = GAP_MAX;

  cll_req_if req ();
  cll_res_if res ();
  cll_cfg_if cfg ();

  lock_scoreboard sb = new();

  combination_lock_controller dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .res_o  (res),
    .cfg_i  (cfg)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: give up if the run overstays its budget
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d results still owed", $time, sb.pending());
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Request side helpers: every task starts and ends just after a falling edge
  // --------------------------------------------------------------------------
  function automatic cll_pins_t pin_set(bit a, bit b, bit sel_n, bit confirm, bit clear,
                                        bit door);
    return '{a, b, sel_n, confirm, clear, door};
  endfunction

  // Offer one request after a random gap and hold it until the block takes it
  task automatic send(input cll_pins_t p);
    int gap;
    // pick a bursty or an idle stretch every forty requests
    if (ticks_sent % 40 == 0) tx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid           <= 1'b1;
    req.encoder_a       <= p.encoder_a;
    req.encoder_b       <= p.encoder_b;
    req.select_button_n <= p.select_button_n;
    req.confirm_button  <= p.confirm_button;
    req.clear_button    <= p.clear_button;
    req.door_sensor     <= p.door_sensor;
    do @(posedge clk); while (!req.ready);
    sb.note_request(p);
    ticks_sent++;
    @(negedge clk);
  endtask

  // Quiet tick: no buttons, A low, B random
  task automatic idle_tick(input bit door);
    send(pin_set(1'b0, 1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0, door));
  endtask

  // Press one button, waiting out a short hold-off first
  task automatic press(input button_e k, input bit door);
    int n;
    n = 0;
    if (sb.hold_of(k) <= WAIT_CAP) begin
      while (!sb.will_take(k) && n < WAIT_CAP) begin
        idle_tick(door);
        n++;
      end
    end
    case (k)
      BTN_SELECT:  send(pin_set(1'b0, 1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0, door));
      BTN_CONFIRM: send(pin_set(1'b0, 1'($urandom_range(0, 1)), 1'b1, 1'b1, 1'b0, door));
      default:     send(pin_set(1'b0, 1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b1, door));
    endcase
  endtask

  // One encoder detent: A low, then A high with B giving the direction
  task automatic turn(input bit up, input bit door);
    send(pin_set(1'b0, 1'($urandom_range(0, 1)), 1'b1, 1'b0, 1'b0, door));
    send(pin_set(1'b1, up, 1'b1, 1'b0, 1'b0, door));
  endtask

  // Select a digit and dial it to the target the short way round
  task automatic set_digit(input int pos, input int target, input bit door);
    int n;
    int up;
    n = 0;
    while (int'(sb.dsel) != pos && n < 4) begin
      press(BTN_SELECT, door);
      n++;
    end
    if (int'(sb.dsel) != pos) return;
    up = (target - int'(sb.digit[pos]) + 10) % 10;
    if (up <= 5) begin
      repeat (up) turn(1'b1, door);
    end else begin
      repeat (10 - up) turn(1'b0, door);
    end
  endtask

  task automatic enter_code(input int value, input bit door);
    set_digit(0, value / 100, door);
    set_digit(1, value / 10 % 10, door);
    set_digit(2, value % 10, door);
  endtask

  task automatic wait_out_lockout();
    int n;
    n = 0;
    while (sb.mode == MODE_BLOCKED && n < LOCKOUT_CAP) begin
      idle_tick(1'b0);
      n++;
    end
  endtask

  // Random pin soup: buttons mostly released, select mostly high
  task automatic noise(input int len);
    repeat (len) begin
      send(pin_set(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 3) != 0, $urandom_range(0, 4) == 0,
                   $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0));
    end
  endtask

  // Drop valid and wait for every owed result, then let the block settle
  task automatic settle();
    int n;
    n = 0;
    req.valid <= 1'b0;
    while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_settings(input int tries_max, input int secs, input int btn_hold,
                                input int sel_hold, input int rate);
    settle();
    write_reg(CFG_MAX_TRIES,        CFG_DATA_W'(tries_max));
    write_reg(CFG_LOCKOUT_SECONDS,  CFG_DATA_W'(secs));
    write_reg(CFG_BUTTON_HOLDOFF,   CFG_DATA_W'(btn_hold));
    write_reg(CFG_SELECT_HOLDOFF,   CFG_DATA_W'(sel_hold));
    write_reg(CFG_TICKS_PER_SECOND, CFG_DATA_W'(rate));
  endtask

  // --------------------------------------------------------------------------
  // Sequenced random traffic: mostly well-formed operator sessions
  // --------------------------------------------------------------------------
  task automatic run_phase(input int len);
    int  stop;
    int  pick;
    int  value;
    int  n;
    bit  door;
    stop = ticks_sent + len;
    while (ticks_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (sb.mode == MODE_BLOCKED && pick < 50) begin
        wait_out_lockout();
      end else if (sb.mode == MODE_BLOCKED || pick < 40) begin
        // unlock attempt; the door forces closed handling while blocked
        door = (sb.mode == MODE_BLOCKED) || ($urandom_range(0, 9) == 0);
        if (sb.mode == MODE_OPEN && !door) press(BTN_CONFIRM, 1'b0);
        if ($urandom_range(0, 4) == 0) press(BTN_CLEAR, door);
        value = ($urandom_range(0, 2) != 0) ? int'(sb.stored) : $urandom_range(0, 999);
        enter_code(value, door);
        press(BTN_CONFIRM, door);
      end else if (pick < 60) begin
        // open with the right code, then store a fresh one
        if (sb.mode == MODE_CLOSED) begin
          enter_code(int'(sb.stored), 1'b0);
          press(BTN_CONFIRM, 1'b0);
        end
        if (sb.mode == MODE_OPEN) press(BTN_CLEAR, 1'b0);
        if (sb.mode == MODE_SETTING) begin
          enter_code($urandom_range(0, 999), 1'b0);
          press(BTN_CONFIRM, 1'b0);
        end
      end else if (pick < 75) begin
        // burn every try with a wrong code and sit out the lockout
        if (sb.mode == MODE_OPEN) press(BTN_CONFIRM, 1'b0);
        value = $urandom_range(0, 999);
        if (value == int'(sb.stored)) value = (value + 1) % 1000;
        enter_code(value, 1'b0);
        n = 0;
        while (sb.mode == MODE_CLOSED && n < 16) begin
          press(BTN_CONFIRM, 1'b0);
          n++;
        end
        wait_out_lockout();
      end else begin
        noise($urandom_range(5, 25));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, two long hold-offs to back the block up
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int         stall;
    int         rx_gap_max;
    lock_view_t got;
    rx_gap_max = GAP_MAX;
    res.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (sb.checked % 40 == 0) rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
      if (sb.checked == 250 || sb.checked == 1000) begin
        stall = LONG_HOLD;
      end else begin
        stall = $urandom_range(0, rx_gap_max);
      end
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      got = '{res.mode, res.selected_digit, res.digit_one, res.digit_two, res.digit_three,
              res.bolt_open, res.green_led, res.red_led, res.event_res, res.tries_left};
      sb.check_result(got);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    // hold every input at a known level from time zero
    rst_n               = 1'b0;
    req.valid           = 1'b0;
    req.encoder_a       = 1'b0;
    req.encoder_b       = 1'b0;
    req.select_button_n = 1'b1;
    req.confirm_button  = 1'b0;
    req.clear_button    = 1'b0;
    req.door_sensor     = 1'b0;
    cfg.valid           = 1'b0;
    cfg.index           = CFG_MAX_TRIES;
    cfg.data            = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings: buttons still inside their hold-off, encoder wrap
    send(pin_set(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send(pin_set(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0));  // all presses too early
    send(pin_set(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));  // A rises, B high: up
    send(pin_set(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));  // A held: no step
    send(pin_set(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send(pin_set(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));  // down to zero
    send(pin_set(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
    send(pin_set(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));  // down wraps to nine
    send(pin_set(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
    send(pin_set(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));  // up wraps to zero

    // Drop hold-offs, fast countdown; a write to an unused index must be lost
    write_settings(3, 2, 0, 0, 1);
    write_reg(CFG_UNUSED, '1);
    send(pin_set(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));  // select the second digit
    send(pin_set(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));  // 000 matches: open
    send(pin_set(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));  // clear while open: set code
    send(pin_set(1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0));  // dial second digit up
    send(pin_set(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));  // save 010
    send(pin_set(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0));  // clear the digits
    send(pin_set(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));  // wrong code
    send(pin_set(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));  // wrong code, one try left
    send(pin_set(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0));  // last try: block
    send(pin_set(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1));  // door + wrong with no tries
    send(pin_set(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));  // door, every pin high
    wait_out_lockout();

    // Extreme settings first, then random ones until the tick budget is spent
    write_settings(15, 99, 0, 0, 1);
    run_phase(220);
    write_settings(1, 0, 65535, 65535, 65535);
    run_phase(60);
    write_settings(1, 0, 1, 2, 1);
    run_phase(200);
    while (ticks_sent < TOTAL_TICKS) begin
      write_settings($urandom_range(1, 15),
                     ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : $urandom_range(0, 99),
                     ($urandom_range(0, 4) != 0) ? $urandom_range(0, 6) : $urandom_range(0, 65535),
                     ($urandom_range(0, 4) != 0) ? $urandom_range(0, 6) : $urandom_range(0, 65535),
                     ($urandom_range(0, 4) != 0) ? $urandom_range(1, 5) : $urandom_range(1, 65535));
      run_phase(150);
    end

    settle();
    $display("%0d ticks driven, %0d results checked, %0d mismatches, %0d owed",
             ticks_sent, sb.checked, sb.errors, sb.pending());
    $display("events: %0d wrong, %0d lockouts, %0d opened, %0d saved, %0d lockouts over",
             sb.ev_seen[EV_WRONG], sb.ev_seen[EV_LOCKOUT], sb.ev_seen[EV_OPENED],
             sb.ev_seen[EV_SAVED], sb.ev_seen[EV_OVER]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
